// ----- rtl/core/rhds_pkg.sv -----
// ============================================================================
// rhds_pkg
// Shared types, constants and the 1/(2i) reciprocal table for the radial
// heat diffusion step unit.
// ============================================================================
`default_nettype none

package rhds_pkg;

    // Profile geometry
    localparam int NUM_POINTS = 32;
    localparam int ADDR_W     = $clog2(NUM_POINTS);

    // Reset temperatures, signed Q8.8
    localparam logic signed [15:0] AMBIENT_Q88 = 16'sd3840;
    localparam logic signed [15:0] CENTRE_Q88  = 16'sd6144;

    // Configuration
    localparam logic [15:0] GAIN_RESET = 16'd954;
    localparam int          PADDR_W    = 3;
    localparam logic        REG_GAIN   = 1'b0;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LOAD,
        S_C2,
        S_LAP,
        S_DIF,
        S_ROUND
    } t_state;

    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [15:0]       wr_data;
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
    } t_mem_req;

    // Unsigned Q0.16 value of 1/(2i), rounded half up
    function automatic logic [15:0] recip_half(input logic [5:0] idx);
        logic [15:0] r;
        case (idx)
            6'd1:  r = 16'd32768;
            6'd2:  r = 16'd16384;
            6'd3:  r = 16'd10923;
            6'd4:  r = 16'd8192;
            6'd5:  r = 16'd6554;
            6'd6:  r = 16'd5461;
            6'd7:  r = 16'd4681;
            6'd8:  r = 16'd4096;
            6'd9:  r = 16'd3641;
            6'd10: r = 16'd3277;
            6'd11: r = 16'd2979;
            6'd12: r = 16'd2731;
            6'd13: r = 16'd2521;
            6'd14: r = 16'd2341;
            6'd15: r = 16'd2185;
            6'd16: r = 16'd2048;
            6'd17: r = 16'd1928;
            6'd18: r = 16'd1820;
            6'd19: r = 16'd1725;
            6'd20: r = 16'd1638;
            6'd21: r = 16'd1560;
            6'd22: r = 16'd1489;
            6'd23: r = 16'd1425;
            6'd24: r = 16'd1365;
            6'd25: r = 16'd1311;
            6'd26: r = 16'd1260;
            6'd27: r = 16'd1214;
            6'd28: r = 16'd1170;
            6'd29: r = 16'd1130;
            6'd30: r = 16'd1092;
            6'd31: r = 16'd1057;
            6'd32: r = 16'd1024;
            6'd33: r = 16'd993;
            6'd34: r = 16'd964;
            6'd35: r = 16'd936;
            6'd36: r = 16'd910;
            6'd37: r = 16'd886;
            6'd38: r = 16'd862;
            6'd39: r = 16'd840;
            6'd40: r = 16'd819;
            6'd41: r = 16'd799;
            6'd42: r = 16'd780;
            6'd43: r = 16'd762;
            6'd44: r = 16'd745;
            6'd45: r = 16'd728;
            6'd46: r = 16'd712;
            6'd47: r = 16'd697;
            6'd48: r = 16'd683;
            6'd49: r = 16'd669;
            6'd50: r = 16'd655;
            6'd51: r = 16'd643;
            6'd52: r = 16'd630;
            6'd53: r = 16'd618;
            6'd54: r = 16'd607;
            6'd55: r = 16'd596;
            6'd56: r = 16'd585;
            6'd57: r = 16'd575;
            6'd58: r = 16'd565;
            6'd59: r = 16'd555;
            6'd60: r = 16'd546;
            6'd61: r = 16'd537;
            6'd62: r = 16'd529;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/radial_heat_diffusion_step_unit.sv -----
// ============================================================================
// radial_heat_diffusion_step_unit
// Radial FTCS heat diffusion on a Q8.8 temperature profile, one shared
// multiplier under a small sequencer.
// ============================================================================
`default_nettype none

// A load item (cmd 0) writes one profile point and gives no result; an index
// at or beyond NUM_POINTS is dropped. A step item (cmd 1) recomputes all
// NUM_POINTS points from the old profile and emits them in index order, last
// set on the outermost point. The input side is stalled for the whole step.
// A step first reads the first two points into the three-point window, then
// handles the centre (centre-term product, round), each interior point (load,
// radial coefficient, laplacian product, difference product, round) and
// finally the held outer point (load, round). The single multiplier is
// visited three times by an interior point (gain*recip for the radial
// coefficient, gain*laplacian, coefficient*difference), besides a load state
// for the memory read and a round, saturate and write-back state. Each result
// sits in an output register, so the sequencer only waits on the output when
// a new point is ready and the previous one has not been taken. After reset
// the profile reads 24.0 at the centre and 15.0 elsewhere, with no clearing
// pass. The gain register (unsigned Q0.16, reset 954) sits at APB address 0;
// the user must write it only while the block is idle; the block leaves this unchecked.

module radial_heat_diffusion_step_unit
    import rhds_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // input items
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_cmd,
    input  wire logic [5:0]         i_point_index,
    input  wire logic signed [15:0] i_point_temperature,

    // result items
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [5:0]              o_out_index,
    output logic signed [15:0]      o_out_temperature,
    output logic                    o_last,

    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_pt, n_pt;         // point being computed
    logic [ADDR_W-1:0]      r_addr, n_addr;     // next address to read
    logic                   r_prime, n_prime;   // window still filling
    logic signed [15:0]     r_prev, n_prev;
    logic signed [15:0]     r_cur, n_cur;
    logic signed [15:0]     r_nxt, n_nxt;
    logic [15:0]            r_c2, n_c2;
    logic signed [35:0]     r_acc, n_acc;
    logic [15:0]            r_gain;

    logic                   r_out_valid, n_out_valid;
    logic [5:0]             r_out_index, n_out_index;
    logic signed [15:0]     r_out_temp, n_out_temp;
    logic                   r_out_last, n_out_last;

    t_mem_req               mem_req;
    logic signed [15:0]     mem_rd_data;
    logic signed [18:0]     mul_a;
    logic [15:0]            mul_b;
    logic signed [35:0]     mul_prod;

    logic signed [18:0]     op_lap;
    logic signed [18:0]     op_centre;
    logic signed [18:0]     op_dif;
    logic [31:0]            c2_sum;
    logic signed [35:0]     round_sum;
    logic signed [21:0]     new_sum;
    logic signed [15:0]     new_sat;
    logic                   out_free;
    logic                   pt_last;
    logic                   load_ok;

    rhds_profile_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    rhds_mul u_mul (
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAIN) ? {16'd0, r_gain} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAIN) begin
            r_gain <= pwdata[15:0];
        end
    end

    // ---------------- window arithmetic ----------------
    // Laplacian, centre term and central difference from the old values.
    assign op_lap    = 19'(r_nxt) + 19'(r_prev) - (19'(r_cur) <<< 1);
    assign op_centre = (19'(r_nxt) - 19'(r_cur)) <<< 1;
    assign op_dif    = 19'(r_nxt) - 19'(r_prev);

    // Radial coefficient, rounded half up to Q0.16; never exceeds 32768.
    assign c2_sum    = mul_prod[31:0] + 32'd32768;

    // Round the Q8.24 increment half up to Q8.8, add the old value, saturate.
    assign round_sum = r_acc + 36'sd32768;
    assign new_sum   = 22'(r_cur) + 22'($signed(round_sum[35:16]));

    always_comb begin
        if (new_sum > 22'sd32767) begin
            new_sat = 16'sh7FFF;
        end else if (new_sum < -22'sd32768) begin
            new_sat = 16'sh8000;
        end else begin
            new_sat = new_sum[15:0];
        end
    end

    assign out_free = !r_out_valid || !i_stall;
    assign pt_last  = (r_pt == ADDR_W'(NUM_POINTS - 1));
    assign load_ok  = ({1'b0, i_point_index} < 7'(NUM_POINTS));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_pt        = r_pt;
        n_addr      = r_addr;
        n_prime     = r_prime;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_nxt       = r_nxt;
        n_c2        = r_c2;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out_index = r_out_index;
        n_out_temp  = r_out_temp;
        n_out_last  = r_out_last;
        mem_req     = '0;
        mul_a       = '0;
        mul_b       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_STEP) begin
                        n_state = S_RD;
                        n_pt    = '0;
                        n_addr  = '0;
                        n_prime = 1'b1;
                    end else if (load_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = i_point_index[ADDR_W-1:0];
                        mem_req.wr_data = i_point_temperature;
                    end
                end
            end

            S_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_addr;
                if (r_addr != ADDR_W'(NUM_POINTS - 1)) begin
                    n_addr = r_addr + 1'b1;
                end
                n_state = S_LOAD;
            end

            S_LOAD: begin
                // advance the window by one old value
                n_prev = r_cur;
                n_cur  = r_nxt;
                n_nxt  = mem_rd_data;
                if (r_prime) begin
                    n_prime = 1'b0;
                    n_state = S_RD;
                end else if (r_pt == '0) begin
                    n_state = S_LAP;
                end else if (pt_last) begin
                    n_acc   = '0;
                    n_state = S_ROUND;
                end else begin
                    n_state = S_C2;
                end
            end

            S_C2: begin
                mul_a   = {3'b000, recip_half(6'(r_pt))};
                mul_b   = r_gain;
                n_c2    = c2_sum[31:16];
                n_state = S_LAP;
            end

            S_LAP: begin
                mul_a   = (r_pt == '0) ? op_centre : op_lap;
                mul_b   = r_gain;
                n_acc   = mul_prod;
                n_state = (r_pt == '0) ? S_ROUND : S_DIF;
            end

            S_DIF: begin
                mul_a   = op_dif;
                mul_b   = r_c2;
                n_acc   = r_acc + mul_prod;
                n_state = S_ROUND;
            end

            S_ROUND: begin
                // hold until the output register can take the point
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_index     = 6'(r_pt);
                    n_out_temp      = new_sat;
                    n_out_last      = pt_last;
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_pt;
                    mem_req.wr_data = new_sat;
                    if (pt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = r_addr;
                        if (r_addr != ADDR_W'(NUM_POINTS - 1)) begin
                            n_addr = r_addr + 1'b1;
                        end
                        n_pt    = r_pt + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt        <= '0;
            r_addr      <= '0;
            r_prime     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pt        <= n_pt;
            r_addr      <= n_addr;
            r_prime     <= n_prime;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_nxt       <= n_nxt;
        r_c2        <= n_c2;
        r_acc       <= n_acc;
        r_out_index <= n_out_index;
        r_out_temp  <= n_out_temp;
        r_out_last  <= n_out_last;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_out_index       = r_out_index;
    assign o_out_temperature = r_out_temp;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_STEP) |=> (r_state == S_RD && r_pt == '0))
        else $error("step item did not start the sequencer at point zero");

    a_round_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_out_valid && i_stall) |=>
            (r_state == S_ROUND && $stable(r_pt)))
        else $error("point advanced while the output register was full");

    a_next_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (7'(r_pt) == 7'(o_out_index) + 7'd1))
        else $error("point counter out of step with emitted index");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_out_index == 6'(NUM_POINTS - 1)))
        else $error("last flag on a point other than the outermost");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rhds_mul.sv -----
// ============================================================================
// rhds_mul
// Shared signed by unsigned multiplier used by every product of a step.
// ============================================================================
`default_nettype none

module rhds_mul
    import rhds_pkg::*;
(
    input  wire logic signed [18:0] i_a,
    input  wire logic        [15:0] i_b,
    output logic signed      [35:0] o_prod
);

    assign o_prod = i_a * $signed({1'b0, i_b});

endmodule

`default_nettype wire

// ----- rtl/core/rhds_profile_mem.sv -----
// ============================================================================
// rhds_profile_mem
// Profile store: one write and one registered read per cycle, with a valid
// bit per entry so unwritten entries read as their reset temperature.
// ============================================================================
`default_nettype none

module rhds_profile_mem
    import rhds_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mem_req           i_req,
    output logic signed [15:0]      o_rd_data
);

    logic signed [15:0]     r_mem [NUM_POINTS];
    logic [NUM_POINTS-1:0]  r_valid;
    logic signed [15:0]     r_rd_data;
    logic                   r_rd_valid;
    logic                   r_rd_centre;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_centre <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid  <= r_valid[i_req.rd_addr];
                r_rd_centre <= (i_req.rd_addr == '0);
            end
        end
    end

    assign o_rd_data = r_rd_valid  ? r_rd_data  :
                       r_rd_centre ? CENTRE_Q88 : AMBIENT_Q88;

endmodule

`default_nettype wire
